/* rtl/additive_harmonic_waveform_core_defines.svh */
// Assertion macros for the additive harmonic waveform core.
// All checks sample on the rising edge of clk and are off while arst_n is low.
`ifndef ADDITIVE_HARMONIC_WAVEFORM_CORE_DEFINES_SVH
`define ADDITIVE_HARMONIC_WAVEFORM_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication
`define AHW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ahw: same-cycle check failed");
// Next-cycle implication
`define AHW_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ahw: next-cycle check failed");
`else
`define AHW_ASSERT_IMP(lbl, ante, cons)
`define AHW_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/ahw_pkg.sv */
package ahw_pkg;

	// Sizes
	localparam int NUM_HARMONICS_DEF = 32;
	localparam int MAX_PERIOD        = 4096;
	localparam int SINE_ENTRIES      = 1024;

	// Field and register widths
	localparam int PERIOD_W = 13;
	localparam int OGAIN_W  = 8;
	localparam int HCOUNT_W = 6;
	localparam int HNUM_W   = 6;
	localparam int HGAIN_W  = 16;
	localparam int T_W      = 12;
	localparam int BYTE_W   = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// Datapath widths
	localparam int IDX_W      = $clog2(SINE_ENTRIES);
	localparam int QTR_ENT    = SINE_ENTRIES / 4;
	localparam int SINE_MAG_W = 15;
	localparam int SINE_W     = SINE_MAG_W + 1;
	localparam int PER_EFF_W  = $clog2(MAX_PERIOD + 1);
	localparam int REM_W      = PER_EFF_W + 1;
	localparam int DIVIDEND_W = T_W + IDX_W;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
	localparam int PROD_W     = HGAIN_W + SINE_W;
	localparam int FRAC_BITS  = 23;

	localparam logic [BYTE_W-1:0] SILENCE_LEVEL = 8'h80;

	// Reset values of the configuration registers
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 13'd100;
	localparam logic [OGAIN_W-1:0]  OGAIN_RST  = 8'd64;
	localparam logic [HCOUNT_W-1:0] HCOUNT_RST = 6'd1;

	// pi in Q2.62
	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD         = 2'd0,
		REG_OUTPUT_GAIN    = 2'd1,
		REG_HARMONIC_COUNT = 2'd2
	} reg_idx_t;

	localparam logic ACT_GAIN_WRITE = 1'b0;
	localparam logic ACT_SAMPLE     = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_WALK,
		ST_DRAIN,
		ST_SCALE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic gain_write;
		logic div_load;
		logic div_step;
		logic walk_issue;
		logic scale;
		logic out_load;
	} ahw_cmd_t;

	typedef struct packed {
		logic div_done;
		logic walk_done;
		logic pipe_empty;
	} ahw_stat_t;

	// (a*b) >> 62, low 64 bits
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// Q1.15 magnitude of sin(2*pi*j/SINE_ENTRIES) for j in the first quarter wave
	function automatic logic [SINE_MAG_W-1:0] sine_quarter(input int unsigned j);
		logic [63:0] p2;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] mag;
		logic        sub;
		p2   = 64'(2 * j);
		q    = PI_Q62 / 64'(SINE_ENTRIES);
		r    = PI_Q62 % 64'(SINE_ENTRIES);
		x    = q * p2 + (r * p2) / 64'(SINE_ENTRIES);
		x2   = mul_q62(x, x);
		term = x;
		sum  = x;
		sub  = 1'b1;
		for (int k = 3; k <= 29; k += 2) begin
			term = mul_q62(term, x2) / 64'((k - 1) * k);
			if (sub) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
			sub = !sub;
		end
		mag = (sum + (64'd1 << 46)) >> 47;
		if (mag > 64'd32767) begin
			mag = 64'd32767;
		end
		return mag[SINE_MAG_W-1:0];
	endfunction

endpackage

/* rtl/ahw_sine_rom.sv */
module ahw_sine_rom
	import ahw_pkg::*;
(
	input  logic                  clk,
	input  logic [IDX_W-1:0]      idx,
	output logic [SINE_MAG_W-1:0] mag_s1,
	output logic                  neg_s1
);

	localparam logic [IDX_W-1:0] HALF = IDX_W'(SINE_ENTRIES / 2);

	logic [SINE_MAG_W-1:0] qtr_rom [QTR_ENT+1];
	logic [IDX_W-2:0]      half_idx;
	logic [IDX_W-2:0]      qtr_idx;

	// Quarter-wave table, filled at elaboration
	for (genvar g = 0; g <= QTR_ENT; g++) begin : g_rom
		localparam logic [SINE_MAG_W-1:0] ENTRY = sine_quarter(g);
		assign qtr_rom[g] = ENTRY;
	end

	// Fold the full-wave index into the first quarter
	assign half_idx = idx[IDX_W-2:0];
	assign qtr_idx  = (32'(half_idx) > QTR_ENT) ?
		(IDX_W-1)'(HALF - {1'b0, half_idx}) : half_idx;

	// Registered read; the second half of the wave is negative
	always_ff @(posedge clk) begin
		mag_s1 <= qtr_rom[qtr_idx];
		neg_s1 <= idx[IDX_W-1];
	end

endmodule

/* rtl/ahw_gain_mem.sv */
module ahw_gain_mem
	import ahw_pkg::*;
#(
	parameter int NUM_HARMONICS = NUM_HARMONICS_DEF,
	parameter int HA_W          = (NUM_HARMONICS > 1) ? $clog2(NUM_HARMONICS) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      we,
	input  logic [HA_W-1:0]           waddr,
	input  logic signed [HGAIN_W-1:0] wdata,
	input  logic [HA_W-1:0]           raddr,
	output logic signed [HGAIN_W-1:0] rdata
);

	logic signed [HGAIN_W-1:0] mem_q [NUM_HARMONICS];
	logic [NUM_HARMONICS-1:0]  valid_q;
	logic signed [HGAIN_W-1:0] word_s1;
	logic                      word_valid_s1;

	// Store a gain
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Mark written entries; reset empties the whole table at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		word_s1       <= mem_q[raddr];
		word_valid_s1 <= valid_q[raddr];
	end

	// Unwritten entries read as zero
	assign rdata = word_valid_s1 ? word_s1 : '0;

endmodule

/* rtl/ahw_datapath.sv */
module ahw_datapath
	import ahw_pkg::*;
#(
	parameter int NUM_HARMONICS = NUM_HARMONICS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ahw_cmd_t                  cmd,
	output ahw_stat_t                 stat,
	input  logic [HNUM_W-1:0]         harmonic_number,
	input  logic signed [HGAIN_W-1:0] harmonic_gain,
	input  logic [T_W-1:0]            sample_index,
	input  logic [PERIOD_W-1:0]       period_cfg,
	input  logic [OGAIN_W-1:0]        ogain_cfg,
	input  logic [HCOUNT_W-1:0]       hcount_cfg,
	output logic [BYTE_W-1:0]         sample_byte
);

	localparam int HA_W    = (NUM_HARMONICS > 1) ? $clog2(NUM_HARMONICS) : 1;
	localparam int CNT_W   = $clog2(NUM_HARMONICS + 1);
	localparam int ACC_W   = PROD_W + $clog2(NUM_HARMONICS + 1);
	localparam int SCALE_W = ACC_W + OGAIN_W + 1;
	localparam logic [SCALE_W-1:0] TRUNC_BIAS = SCALE_W'((64'd1 << FRAC_BITS) - 64'd1);

	logic [PER_EFF_W-1:0] per_eff;
	logic [CNT_W-1:0]     count_eff;

	logic                 gain_we;
	logic [HA_W-1:0]      gain_waddr;

	logic [DIVIDEND_W-1:0] dvd_q;
	logic [REM_W-1:0]      rem_q;
	logic [IDX_W-1:0]      quo_q;
	logic [DIV_CNT_W-1:0]  dcnt_q;
	logic [REM_W-1:0]      trial;
	logic                  trial_ge;

	logic [IDX_W-1:0]     idx_q;
	logic [PER_EFF_W-1:0] frac_q;
	logic [CNT_W-1:0]     hcnt_q;
	logic [REM_W-1:0]     fsum;
	logic                 fcarry;
	logic [PER_EFF_W-1:0] frac_nx;
	logic [IDX_W-1:0]     idx_nx;

	logic                 v_s0;
	logic                 v_s1;
	logic                 v_s2;
	logic [HA_W-1:0]      haddr_s0;

	logic [SINE_MAG_W-1:0]     mag_s1;
	logic                      neg_s1;
	logic signed [HGAIN_W-1:0] gain_s1;
	logic signed [SINE_W-1:0]  sine_val;
	logic signed [PROD_W-1:0]  prod_s2;

	logic signed [ACC_W-1:0]   acc_q;
	logic signed [OGAIN_W:0]   ogain_s;
	logic signed [SCALE_W-1:0] scaled_d;
	logic signed [SCALE_W-1:0] scaled_q;
	logic [SCALE_W-1:0]        rounded;
	logic [BYTE_W-1:0]         byte_nx;
	logic [BYTE_W-1:0]         sample_byte_q;

	// Clamp period and harmonic count to the supported range
	assign per_eff = (period_cfg == '0) ? PER_EFF_W'(1) :
		(32'(period_cfg) > MAX_PERIOD) ? PER_EFF_W'(MAX_PERIOD) : PER_EFF_W'(period_cfg);
	assign count_eff = (32'(hcount_cfg) > NUM_HARMONICS) ?
		CNT_W'(NUM_HARMONICS) : CNT_W'(hcount_cfg);

	// Gain table write; drop out-of-range harmonic numbers
	assign gain_we = cmd.gain_write && (harmonic_number != '0) &&
		(32'(harmonic_number) <= NUM_HARMONICS);
	assign gain_waddr = HA_W'(harmonic_number - HNUM_W'(1));

	ahw_gain_mem #(
		.NUM_HARMONICS (NUM_HARMONICS),
		.HA_W          (HA_W)
	) u_gain_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (gain_we),
		.waddr  (gain_waddr),
		.wdata  (harmonic_gain),
		.raddr  (haddr_s0),
		.rdata  (gain_s1)
	);

	// Restoring divide of t*SINE_ENTRIES by the period, one quotient bit per cycle.
	// The low quotient bits are the per-harmonic index step, the remainder its fraction.
	assign trial    = {rem_q[REM_W-2:0], dvd_q[DIVIDEND_W-1]};
	assign trial_ge = trial >= {1'b0, per_eff};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			dvd_q <= {sample_index, IDX_W'(0)};
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DIVIDEND_W-2:0], 1'b0};
			rem_q <= trial_ge ? (trial - {1'b0, per_eff}) : trial;
			quo_q <= {quo_q[IDX_W-2:0], trial_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_load) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + DIV_CNT_W'(1);
		end
	end

	assign stat.div_done = (dcnt_q == DIV_CNT_W'(DIVIDEND_W));

	// Phase walk: add the step to (index, fraction), carry the fraction into the index
	assign fsum    = {1'b0, frac_q} + {1'b0, rem_q[PER_EFF_W-1:0]};
	assign fcarry  = fsum >= {1'b0, per_eff};
	assign frac_nx = fcarry ? PER_EFF_W'(fsum - {1'b0, per_eff}) : PER_EFF_W'(fsum);
	assign idx_nx  = idx_q + quo_q + IDX_W'(fcarry);

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			idx_q  <= '0;
			frac_q <= '0;
		end else if (cmd.walk_issue) begin
			idx_q    <= idx_nx;
			frac_q   <= frac_nx;
			haddr_s0 <= hcnt_q[HA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q <= '0;
		end else if (cmd.div_load) begin
			hcnt_q <= '0;
		end else if (cmd.walk_issue) begin
			hcnt_q <= hcnt_q + CNT_W'(1);
		end
	end

	assign stat.walk_done = (hcnt_q == count_eff);

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s0 <= cmd.walk_issue;
			v_s1 <= v_s0;
			v_s2 <= v_s1;
		end
	end

	assign stat.pipe_empty = !(v_s0 || v_s1 || v_s2);

	ahw_sine_rom u_sine_rom (
		.clk    (clk),
		.idx    (idx_q),
		.mag_s1 (mag_s1),
		.neg_s1 (neg_s1)
	);

	// Multiply gain by signed sine
	assign sine_val = neg_s1 ? -$signed({1'b0, mag_s1}) : $signed({1'b0, mag_s1});

	always_ff @(posedge clk) begin
		prod_s2 <= gain_s1 * sine_val;
	end

	// Accumulate the products
	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Scale by the output gain
	assign ogain_s  = $signed({1'b0, ogain_cfg});
	assign scaled_d = acc_q * ogain_s;

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			scaled_q <= scaled_d;
		end
	end

	// Drop the fraction toward zero, then offset to unsigned
	assign rounded = scaled_q + (scaled_q[SCALE_W-1] ? TRUNC_BIAS : '0);
	assign byte_nx = rounded[FRAC_BITS +: BYTE_W] + SILENCE_LEVEL;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sample_byte_q <= byte_nx;
		end
	end

	assign sample_byte = sample_byte_q;

endmodule

/* rtl/ahw_ctrl.sv */
module ahw_ctrl
	import ahw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      action,
	output logic      out_valid,
	input  logic      out_ready,
	output ahw_cmd_t  cmd,
	input  ahw_stat_t stat
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (action == ACT_SAMPLE)) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (stat.walk_done) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.pipe_empty) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.gain_write = accept && (action == ACT_GAIN_WRITE);
				cmd.div_load   = accept && (action == ACT_SAMPLE);
			end
			ST_DIV: begin
				cmd.div_step = !stat.div_done;
			end
			ST_WALK: begin
				cmd.walk_issue = !stat.walk_done;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
			end
			ST_FINISH: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/additive_harmonic_waveform_core.sv */
// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_ready     action, harmonic_number, harmonic_gain,
//                                              sample_index
// output    out        out_valid / out_ready   sample_byte
// config    in         cfg_we (no wait)        cfg_index, cfg_data
//
// A gain write produces no result. A sample runs through the bit-serial divider, then the
// walk of one harmonic at a time through the ROM and multiplier, a drain of the pipeline,
// then scale and load.
// Reset restores the register defaults and empties the gain table at once.
// A finished sample waits in the output register; a new item is taken once it is loaded
// there; input stalls from a sample's acceptance until that load.
`include "additive_harmonic_waveform_core_defines.svh"

module additive_harmonic_waveform_core
	import ahw_pkg::*;
#(
	parameter int NUM_HARMONICS = NUM_HARMONICS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      action,
	input  logic [HNUM_W-1:0]         harmonic_number,
	input  logic signed [HGAIN_W-1:0] harmonic_gain,
	input  logic [T_W-1:0]            sample_index,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [BYTE_W-1:0]         sample_byte,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	logic [PERIOD_W-1:0] period_q;
	logic [OGAIN_W-1:0]  ogain_q;
	logic [HCOUNT_W-1:0] hcount_q;

	ahw_cmd_t  cmd;
	ahw_stat_t stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			ogain_q  <= OGAIN_RST;
			hcount_q <= HCOUNT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PERIOD: begin
					period_q <= cfg_data[PERIOD_W-1:0];
				end
				REG_OUTPUT_GAIN: begin
					ogain_q <= cfg_data[OGAIN_W-1:0];
				end
				REG_HARMONIC_COUNT: begin
					hcount_q <= cfg_data[HCOUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	ahw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	ahw_datapath #(
		.NUM_HARMONICS (NUM_HARMONICS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.harmonic_number (harmonic_number),
		.harmonic_gain   (harmonic_gain),
		.sample_index    (sample_index),
		.period_cfg      (period_q),
		.ogain_cfg       (ogain_q),
		.hcount_cfg      (hcount_q),
		.sample_byte     (sample_byte)
	);

	// Checks
	`AHW_ASSERT_NXT(a_busy_after_sample, in_valid && in_ready && (action == ACT_SAMPLE), !in_ready)
	`AHW_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid || out_ready)
	`AHW_ASSERT_IMP(a_walk_after_div, cmd.walk_issue, stat.div_done)
	`AHW_ASSERT_IMP(a_scale_drained, cmd.scale, stat.pipe_empty && stat.walk_done)

endmodule

/* tb/sv/additive_harmonic_waveform_core_tb.sv */
module additive_harmonic_waveform_core_tb
	import ahw_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam real PI_VAL       = 3.14159265358979323846;
	localparam int  SETTLE_CYCLES = 80;
	localparam int  HOLD_CYCLES   = 400;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      action = ACT_GAIN_WRITE;
	logic [HNUM_W-1:0]         harmonic_number = '0;
	logic signed [HGAIN_W-1:0] harmonic_gain = '0;
	logic [T_W-1:0]            sample_index = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [BYTE_W-1:0]         sample_byte;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = REG_PERIOD;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;

	// Shadow of the block: sine table, gain table and registers
	int                        sine_lut [SINE_ENTRIES];
	logic signed [HGAIN_W-1:0] harmonic_gains [NUM_HARMONICS_DEF];
	logic [PERIOD_W-1:0]       cur_period;
	logic [OGAIN_W-1:0]        cur_ogain;
	logic [HCOUNT_W-1:0]       cur_count;
	logic [BYTE_W-1:0]         pending_bytes [$];

	int errors = 0;
	int samples_checked = 0;
	int gain_writes = 0;
	int ignored_writes = 0;
	int reg_writes = 0;
	int burst_left = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int rx_mode = 0;
	int rx_cycle = 0;

	additive_harmonic_waveform_core DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.harmonic_number (harmonic_number),
		.harmonic_gain   (harmonic_gain),
		.sample_index    (sample_index),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.sample_byte     (sample_byte),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #2 clk = ~clk;

	// Q1.15 sine entry, built from the first quarter wave by symmetry
	function automatic int sine_q15_of(input int i);
		int  j;
		int  mag;
		real a;
		j = i % (SINE_ENTRIES / 2);
		if (j > SINE_ENTRIES / 4) begin
			j = SINE_ENTRIES / 2 - j;
		end
		a = 2.0 * PI_VAL * j / SINE_ENTRIES;
		mag = $rtoi(32768.0 * $sin(a) + 0.5);
		if (mag > 32767) begin
			mag = 32767;
		end
		return (i >= SINE_ENTRIES / 2) ? -mag : mag;
	endfunction

	// Sum the harmonics at index t, scale, truncate toward zero and wrap to a byte
	function automatic logic [BYTE_W-1:0] predict_sample(input logic [T_W-1:0] t);
		int unsigned per;
		int unsigned cnt;
		int unsigned phase;
		int unsigned pos;
		longint      sum;
		longint      scaled;
		logic [63:0] level;
		per = cur_period;
		if (per == 0) begin
			per = 1;
		end
		if (per > MAX_PERIOD) begin
			per = MAX_PERIOD;
		end
		cnt = cur_count;
		if (cnt > NUM_HARMONICS_DEF) begin
			cnt = NUM_HARMONICS_DEF;
		end
		sum = 0;
		for (int unsigned n = 1; n <= cnt; n++) begin
			phase = (n * t) % per;
			pos = phase * SINE_ENTRIES / per;
			sum += longint'(harmonic_gains[n-1]) * longint'(sine_lut[pos]);
		end
		scaled = (sum * longint'(cur_ogain)) / (longint'(1) << FRAC_BITS);
		level = scaled + 128;
		return level[BYTE_W-1:0];
	endfunction

	// Check each output transfer and pick the next ready level
	always @(posedge clk) begin : rx_side
		logic [BYTE_W-1:0] want;
		rx_cycle++;
		if (arst_n && out_valid && out_ready) begin
			if (pending_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected sample_byte %0d, nothing expected", $time, sample_byte);
			end else begin
				want = pending_bytes.pop_front();
				if (sample_byte !== want) begin
					errors++;
					$display("%0t: sample_byte mismatch: expected %0d, actual %0d",
						$time, want, sample_byte);
				end else begin
					samples_checked++;
				end
			end
		end
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (rx_cycle % 600 == 0) begin
			rx_mode = $urandom_range(0, 3);
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: begin
					out_ready <= 1'b1;
				end
				1: begin
					out_ready <= 1'($urandom_range(0, 1));
				end
				2: begin
					out_ready <= ($urandom_range(0, 3) != 0);
				end
				default: begin
					out_ready <= ((rx_cycle % 11) < 4);
				end
			endcase
		end
	end

	// Offer one item, wait for its transfer, then update the shadow
	task automatic send_item(input logic act, input logic [HNUM_W-1:0] hn,
			input logic [HGAIN_W-1:0] hg, input logic [T_W-1:0] t, input bit paced);
		int gap;
		if (paced && burst_left == 0) begin
			gap = $urandom_range(0, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		in_valid <= 1'b1;
		action <= act;
		harmonic_number <= hn;
		harmonic_gain <= hg;
		sample_index <= t;
		do begin
			@(posedge clk);
		end while (!in_ready);
		if (act == ACT_SAMPLE) begin
			pending_bytes.push_back(predict_sample(t));
		end else if (hn >= 1 && hn <= NUM_HARMONICS_DEF) begin
			harmonic_gains[hn-1] = hg;
			gain_writes++;
		end else begin
			ignored_writes++;
		end
	endtask

	task automatic send_sample(input logic [T_W-1:0] t);
		send_item(ACT_SAMPLE, HNUM_W'($urandom), HGAIN_W'($urandom), t, 1'b0);
	endtask

	task automatic send_gain(input logic [HNUM_W-1:0] hn, input logic [HGAIN_W-1:0] hg);
		send_item(ACT_GAIN_WRITE, hn, hg, T_W'($urandom), 1'b0);
	endtask

	// Drop valid, drain every expected byte and let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three registers back to back; the block must be idle
	task automatic program_regs(input logic [CFG_DATA_W-1:0] per,
			input logic [CFG_DATA_W-1:0] og, input logic [CFG_DATA_W-1:0] cnt);
		cfg_we <= 1'b1;
		cfg_index <= REG_PERIOD;
		cfg_data <= per;
		@(posedge clk);
		cfg_index <= REG_OUTPUT_GAIN;
		cfg_data <= og;
		@(posedge clk);
		cfg_index <= REG_HARMONIC_COUNT;
		cfg_data <= cnt;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_period = per[PERIOD_W-1:0];
		cur_ogain = og[OGAIN_W-1:0];
		cur_count = cnt[HCOUNT_W-1:0];
		reg_writes += 3;
	endtask

	// Mostly samples with well-formed gain writes in between, some stray harmonics
	task automatic random_item(input bit paced);
		logic [HNUM_W-1:0]  hn;
		logic [HGAIN_W-1:0] hg;
		int                 pick;
		int                 top;
		if ($urandom_range(0, 9) < 7) begin
			send_item(ACT_SAMPLE, HNUM_W'($urandom), HGAIN_W'($urandom),
				T_W'($urandom), paced);
		end else begin
			pick = $urandom_range(0, 19);
			top = (cur_count == 0) ? 1 :
				(cur_count > NUM_HARMONICS_DEF) ? NUM_HARMONICS_DEF : cur_count;
			if (pick < 10) begin
				hn = HNUM_W'($urandom_range(1, top));
			end else if (pick < 17) begin
				hn = HNUM_W'($urandom_range(1, NUM_HARMONICS_DEF));
			end else begin
				hn = HNUM_W'($urandom_range(0, 63));
			end
			if ($urandom_range(0, 1) != 0) begin
				hg = HGAIN_W'($urandom);
			end else begin
				hg = HGAIN_W'($urandom_range(0, 1024)) - HGAIN_W'(512);
			end
			send_item(ACT_GAIN_WRITE, hn, hg, T_W'($urandom), paced);
		end
	endtask

	// Empty gain table after reset: every sample is silence
	task automatic test_silence_after_reset();
		send_sample(T_W'(0));
		send_sample(T_W'(37));
	endtask

	// Gain extremes, ignored harmonic numbers and the top harmonic
	task automatic test_gain_table();
		send_gain(HNUM_W'(1), 16'h0100);
		send_sample(T_W'(25));
		send_gain(HNUM_W'(0), 16'h7FFF);
		send_gain(HNUM_W'(33), 16'h7FFF);
		send_gain(HNUM_W'(63), 16'h8000);
		send_sample(T_W'(75));
		send_gain(HNUM_W'(1), 16'h7FFF);
		send_gain(HNUM_W'(2), 16'h8000);
		send_gain(HNUM_W'(NUM_HARMONICS_DEF), 16'h8000);
		send_sample(T_W'(13));
		send_sample(T_W'(4095));
	endtask

	// Register extremes: saturated period and count, zero period, zero count, zero gain
	task automatic test_register_extremes();
		wait_idle();
		program_regs(13'd4096, 13'd255, 13'd32);
		send_sample(T_W'(4095));
		send_sample(T_W'(1));
		wait_idle();
		program_regs(13'd0, 13'd64, 13'd1);
		send_sample(T_W'(123));
		wait_idle();
		program_regs(13'd8191, 13'd0, 13'd63);
		send_sample(T_W'(777));
		wait_idle();
		program_regs(13'd1, 13'd1, 13'd0);
		send_sample(T_W'(4095));
		wait_idle();
		program_regs(13'd4097, 13'h1FFF, 13'd33);
		send_sample(T_W'(2048));
		send_sample(T_W'(3));
	endtask

	// Hold the output off for a long stretch while samples keep coming
	task automatic test_output_backpressure();
		wait_idle();
		program_regs(13'd100, 13'd64, 13'd8);
		hold_requests <= hold_requests + 1;
		for (int i = 0; i < 30; i++) begin
			send_sample(T_W'($urandom));
		end
	endtask

	// Pause the input until every expected byte is out, then resume
	task automatic test_sender_pause();
		for (int r = 0; r < 3; r++) begin
			for (int i = 0; i < 12; i++) begin
				random_item(1'b1);
			end
			in_valid <= 1'b0;
			burst_left = 0;
			do begin
				@(posedge clk);
			end while (pending_bytes.size() != 0);
		end
	endtask

	// Random phases, each under a fresh register setting
	task automatic test_random_phases();
		logic [CFG_DATA_W-1:0] per;
		logic [CFG_DATA_W-1:0] og;
		logic [CFG_DATA_W-1:0] cnt;
		for (int ph = 0; ph < 12; ph++) begin
			case ($urandom_range(0, 9))
				0: per = 13'd0;
				1: per = 13'd1;
				2: per = 13'd4096;
				3: per = 13'd8191;
				4: per = CFG_DATA_W'($urandom_range(4097, 8191));
				5: per = CFG_DATA_W'($urandom_range(2, 16));
				default: per = CFG_DATA_W'($urandom_range(1, 4096));
			endcase
			case ($urandom_range(0, 5))
				0: og = 13'd0;
				1: og = 13'd255;
				default: og = CFG_DATA_W'($urandom_range(0, 255));
			endcase
			case ($urandom_range(0, 6))
				0: cnt = 13'd0;
				1: cnt = 13'd32;
				2: cnt = CFG_DATA_W'($urandom_range(33, 63));
				default: cnt = CFG_DATA_W'($urandom_range(1, 32));
			endcase
			// Junk in the unused upper data bits must be dropped
			og[CFG_DATA_W-1:OGAIN_W] = ($urandom_range(0, 3) == 0) ? 5'($urandom) : '0;
			cnt[CFG_DATA_W-1:HCOUNT_W] = ($urandom_range(0, 3) == 0) ? 7'($urandom) : '0;
			wait_idle();
			program_regs(per, og, cnt);
			for (int i = 0; i < 150; i++) begin
				random_item(1'b1);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < SINE_ENTRIES; i++) begin
			sine_lut[i] = sine_q15_of(i);
		end
		for (int i = 0; i < NUM_HARMONICS_DEF; i++) begin
			harmonic_gains[i] = '0;
		end
		cur_period = PERIOD_RST;
		cur_ogain = OGAIN_RST;
		cur_count = HCOUNT_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_silence_after_reset();
		test_gain_table();
		test_register_extremes();
		test_output_backpressure();
		test_sender_pause();
		test_random_phases();
		wait_idle();

		$display("covered %0d samples checked, %0d gain writes, %0d ignored writes,",
			samples_checked, gain_writes, ignored_writes);
		$display("%0d register writes incl. saturated period/count and zero period/count/gain",
			reg_writes);
		if (errors == 0) begin
			$display("additive_harmonic_waveform_core_tb: PASS");
		end else begin
			$display("additive_harmonic_waveform_core_tb: FAIL");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#8_000_000;
		$display("timeout with %0d bytes still expected", pending_bytes.size());
		$display("additive_harmonic_waveform_core_tb: FAIL");
		$finish;
	end

endmodule
